### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the voice allocator RTL
// All checks sample on clk and are held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold on every clock edge
`define CHK_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define CHK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/nsva_pkg.sv
// ---------------------------------------------------------------------------
// nsva_pkg
// Types, codes and defaults for the note stack voice allocator.
// ---------------------------------------------------------------------------
package nsva_pkg;

    // Default sizes
    localparam int MAX_VOICES_DEF  = 8;
    localparam int STACK_DEPTH_DEF = 16;

    // Field widths
    localparam int OPCODE_W   = 2;
    localparam int PITCH_W    = 7;
    localparam int KIND_W     = 2;
    localparam int VOICE_W    = 3;
    localparam int HELD_W     = 5;
    localparam int VIU_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VOICES_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_NOTE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_SPAN     = 2'd2;

    // Register reset values
    localparam logic [VIU_W-1:0]   VIU_RESET  = 4'd1;
    localparam logic [PITCH_W-1:0] LOW_RESET  = 7'd36;
    localparam logic [PITCH_W-1:0] SPAN_RESET = 7'd61;

    // Event codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_ON      = 2'd0,
        OP_OFF     = 2'd1,
        OP_ALL_OFF = 2'd2
    } nsva_op_t;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_RELEASE = 2'd0,
        KIND_ASSIGN  = 2'd1,
        KIND_STATUS  = 2'd2
    } nsva_kind_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_UPDATE,
        S_WIN_INIT,
        S_KEEP,
        S_REL,
        S_ASSIGN,
        S_STATUS
    } nsva_state_t;

    // Input item
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [PITCH_W-1:0]  pitch;
    } nsva_in_t;

    // Result item
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VOICE_W-1:0] voice;
        logic [PITCH_W-1:0] note;
        logic               gate;
        logic               retrigger;
        logic [HELD_W-1:0]  held_notes;
        logic               last;
    } nsva_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic clear_all;
        logic search_step;
        logic update;
        logic win_init;
        logic keep_step;
        logic rel_init;
        logic rel_step;
        logic gate_chk;
        logic asg_step;
        logic status_emit;
    } nsva_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        nsva_op_t op;
        logic     ok;
        logic     idx_end;
        logic     rel_end;
        logic     rel_need;
        logic     asg_need;
        logic     out_free;
    } nsva_stat_t;

endpackage

### hw/rtl/nsva_ctrl.sv
// ---------------------------------------------------------------------------
// nsva_ctrl
// Sequencer for the voice allocator: steps the datapath through search,
// stack update, window scan, releases, assignments and the status item.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nsva_ctrl
    import nsva_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  nsva_stat_t stat,
    output nsva_cmd_t  cmd
);

    nsva_state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.op) inside
                    OP_ALL_OFF:    state_next = S_STATUS;
                    OP_ON, OP_OFF: state_next = stat.ok ? S_SEARCH : S_STATUS;
                    default:       state_next = S_STATUS;
                endcase
            end
            S_SEARCH:
            begin
                if (stat.idx_end)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:   state_next = S_WIN_INIT;
            S_WIN_INIT: state_next = S_KEEP;
            S_KEEP:
            begin
                if (stat.idx_end)
                begin
                    state_next = S_REL;
                end
            end
            S_REL:
            begin
                if (stat.rel_end)
                begin
                    state_next = S_ASSIGN;
                end
            end
            S_ASSIGN:
            begin
                if (stat.idx_end)
                begin
                    state_next = S_STATUS;
                end
            end
            S_STATUS:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Command decode
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_DECODE:
            begin
                cmd.clear_all = (stat.op == OP_ALL_OFF);
            end
            S_SEARCH:
            begin
                cmd.search_step = !stat.idx_end;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            S_WIN_INIT:
            begin
                cmd.win_init = 1'b1;
            end
            S_KEEP:
            begin
                cmd.rel_init  = stat.idx_end;
                cmd.keep_step = !stat.idx_end;
            end
            S_REL:
            begin
                // a release waits for the output slot, a skip does not
                cmd.gate_chk = stat.rel_end;
                cmd.win_init = stat.rel_end;
                cmd.rel_step = !stat.rel_end && (!stat.rel_need || stat.out_free);
            end
            S_ASSIGN:
            begin
                cmd.asg_step = !stat.idx_end && (!stat.asg_need || stat.out_free);
            end
            S_STATUS:
            begin
                cmd.status_emit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Checks
    `CHK_NEXT(a_accept_decode, in_valid && in_ready, state_reg == S_DECODE, "accept did not decode")
    `CHK_NEXT(a_status_idle, (state_reg == S_STATUS) && stat.out_free, state_reg == S_IDLE, "status did not end item")
    `CHK_SAME(a_emit_slot, cmd.rel_step && stat.rel_need, stat.out_free, "release without free slot")

endmodule

### hw/rtl/nsva_dp.sv
// ---------------------------------------------------------------------------
// nsva_dp
// Datapath: note stack, voice table, config registers, scan counters and
// the output item register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nsva_dp
    import nsva_pkg::*;
#(
    parameter int MAX_VOICES  = MAX_VOICES_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  nsva_in_t              in_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  nsva_cmd_t             cmd,
    output nsva_stat_t            stat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output nsva_out_t             out_item
);

    localparam int SIW = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int VIW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int VCW = $clog2(MAX_VOICES + 1);
    localparam int WW  = (CW > 5) ? CW : 5;

    // State
    logic [PITCH_W-1:0] stack_reg [STACK_DEPTH];
    logic [PITCH_W-1:0] stack_next [STACK_DEPTH];
    logic [PITCH_W-1:0] voice_reg [MAX_VOICES];
    logic [PITCH_W-1:0] voice_next [MAX_VOICES];
    logic [CW-1:0]      held_reg, held_next;
    logic               gate_reg, gate_next;

    // Config
    logic [VIU_W-1:0]   viu_reg, viu_next;
    logic [PITCH_W-1:0] low_reg, low_next;
    logic [PITCH_W-1:0] span_reg, span_next;

    // Item context and scan control
    nsva_op_t           op_reg, op_next;
    logic [PITCH_W-1:0] pitch_reg, pitch_next;
    logic               ok_reg, ok_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [VCW-1:0]     vidx_reg, vidx_next;
    logic [MAX_VOICES-1:0] keep_reg, keep_next;
    logic               found_reg, found_next;
    logic [SIW-1:0]     found_idx_reg, found_idx_next;
    logic               any_reg, any_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    nsva_out_t          out_item_reg, out_item_next;

    // Derived values
    logic [4:0]          nv_eff;
    logic [WW-1:0]       held_w, nv_w;
    logic [CW-1:0]       first;
    logic [PITCH_W-1:0]  rd_entry;
    logic [PITCH_W-1:0]  cur_voice;
    logic [MAX_VOICES-1:0] lane_act, hit, free;
    logic                playing, free_any;
    logic [VIW-1:0]      free_idx;
    logic                idx_end, rel_end, rel_need, asg_need, out_free;
    logic [PITCH_W:0]    lim;
    logic                pitch_ok;
    logic                emit_load;

    // Effective voice count and window start
    always_comb
    begin
        if (viu_reg == '0)
        begin
            nv_eff = 5'd1;
        end
        else if (5'(viu_reg) > 5'(MAX_VOICES))
        begin
            nv_eff = 5'(MAX_VOICES);
        end
        else
        begin
            nv_eff = 5'(viu_reg);
        end
        held_w = WW'(held_reg);
        nv_w   = WW'(nv_eff);
        first  = (held_w > nv_w) ? CW'(held_w - nv_w) : '0;
    end

    // Pitch range check on the incoming item
    assign lim      = {1'b0, low_reg} + {1'b0, span_reg};
    assign pitch_ok = (in_item.pitch != '0) && (in_item.pitch >= low_reg)
                      && ({1'b0, in_item.pitch} < lim);

    // Stack read port and voice lane compares
    assign rd_entry  = stack_reg[idx_reg[SIW-1:0]];
    assign cur_voice = voice_reg[vidx_reg[VIW-1:0]];

    always_comb
    begin
        for (int j = 0; j < MAX_VOICES; j++)
        begin
            lane_act[j] = (WW'(j) < nv_w);
            hit[j]      = lane_act[j] && (voice_reg[j] == rd_entry);
            free[j]     = lane_act[j] && (voice_reg[j] == '0);
        end
    end

    // Lowest free voice
    always_comb
    begin
        free_idx = '0;
        for (int j = MAX_VOICES - 1; j >= 0; j--)
        begin
            if (free[j])
            begin
                free_idx = VIW'(j);
            end
        end
    end

    assign playing  = |hit;
    assign free_any = |free;
    assign idx_end  = (idx_reg >= held_reg);
    assign rel_end  = (vidx_reg == VCW'(MAX_VOICES));
    assign rel_need = !rel_end && (cur_voice != '0) && !keep_reg[vidx_reg[VIW-1:0]];
    assign asg_need = !idx_end && !playing && free_any;
    assign out_free = !out_valid_reg || out_ready;

    // Status to controller
    always_comb
    begin
        stat          = '0;
        stat.op       = op_reg;
        stat.ok       = ok_reg;
        stat.idx_end  = idx_end;
        stat.rel_end  = rel_end;
        stat.rel_need = rel_need;
        stat.asg_need = asg_need;
        stat.out_free = out_free;
    end

    // Next-state logic for all datapath registers
    always_comb
    begin
        stack_next     = stack_reg;
        voice_next     = voice_reg;
        held_next      = held_reg;
        gate_next      = gate_reg;
        viu_next       = viu_reg;
        low_next       = low_reg;
        span_next      = span_reg;
        op_next        = op_reg;
        pitch_next     = pitch_reg;
        ok_next        = ok_reg;
        idx_next       = idx_reg;
        vidx_next      = vidx_reg;
        keep_next      = keep_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        any_next       = any_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        out_item_next  = out_item_reg;
        emit_load      = 1'b0;

        // config writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VOICES_IN_USE: viu_next  = cfg_data[VIU_W-1:0];
                CFG_LOWEST_NOTE:   low_next  = cfg_data[PITCH_W-1:0];
                CFG_NOTE_SPAN:     span_next = cfg_data[PITCH_W-1:0];
                default:           ;
            endcase
        end

        // capture item
        if (cmd.load)
        begin
            op_next    = nsva_op_t'(in_item.opcode);
            pitch_next = in_item.pitch;
            ok_next    = pitch_ok;
            idx_next   = '0;
            found_next = 1'b0;
            any_next   = 1'b0;
        end

        // all notes off
        if (cmd.clear_all)
        begin
            for (int k = 0; k < STACK_DEPTH; k++)
            begin
                stack_next[k] = '0;
            end
            for (int j = 0; j < MAX_VOICES; j++)
            begin
                voice_next[j] = '0;
            end
            held_next = '0;
            gate_next = 1'b0;
        end

        // search stack for the event pitch
        if (cmd.search_step)
        begin
            if ((rd_entry == pitch_reg) && !found_reg)
            begin
                found_next     = 1'b1;
                found_idx_next = idx_reg[SIW-1:0];
            end
            idx_next = idx_reg + CW'(1);
        end

        // push or remove
        if (cmd.update)
        begin
            if ((op_reg == OP_ON) && !found_reg)
            begin
                if (held_reg < CW'(STACK_DEPTH))
                begin
                    stack_next[held_reg[SIW-1:0]] = pitch_reg;
                    held_next = held_reg + CW'(1);
                end
                else
                begin
                    // full: oldest drops out
                    for (int k = 0; k < STACK_DEPTH - 1; k++)
                    begin
                        stack_next[k] = stack_reg[k + 1];
                    end
                    stack_next[STACK_DEPTH - 1] = pitch_reg;
                end
            end
            else if ((op_reg == OP_OFF) && found_reg)
            begin
                // close the gap above the removed entry
                for (int k = 0; k < STACK_DEPTH - 1; k++)
                begin
                    if (SIW'(k) >= found_idx_reg)
                    begin
                        stack_next[k] = stack_reg[k + 1];
                    end
                end
                stack_next[STACK_DEPTH - 1] = '0;
                held_next = held_reg - CW'(1);
            end
        end

        // start a window scan
        if (cmd.win_init)
        begin
            idx_next  = first;
            keep_next = '0;
        end

        // mark voices whose note is still in the window
        if (cmd.keep_step)
        begin
            keep_next = keep_reg | hit;
            idx_next  = idx_reg + CW'(1);
        end

        if (cmd.rel_init)
        begin
            vidx_next = '0;
        end

        // release pass, one voice per step
        if (cmd.rel_step)
        begin
            if (rel_need)
            begin
                voice_next[vidx_reg[VIW-1:0]] = '0;
                emit_load                = 1'b1;
                out_item_next            = '0;
                out_item_next.kind       = KIND_RELEASE;
                out_item_next.voice      = VOICE_W'(vidx_reg);
                out_item_next.gate       = gate_reg;
                out_item_next.held_notes = HELD_W'(held_reg);
            end
            vidx_next = vidx_reg + VCW'(1);
        end

        if (cmd.gate_chk && (held_reg == '0))
        begin
            gate_next = 1'b0;
        end

        // assignment pass, one window note per step
        if (cmd.asg_step)
        begin
            if (asg_need)
            begin
                voice_next[free_idx]     = rd_entry;
                gate_next                = 1'b1;
                any_next                 = 1'b1;
                emit_load                = 1'b1;
                out_item_next            = '0;
                out_item_next.kind       = KIND_ASSIGN;
                out_item_next.voice      = VOICE_W'(free_idx);
                out_item_next.note       = rd_entry;
                out_item_next.gate       = 1'b1;
                out_item_next.retrigger  = 1'b1;
                out_item_next.held_notes = HELD_W'(held_reg);
            end
            idx_next = idx_reg + CW'(1);
        end

        // closing status item
        if (cmd.status_emit)
        begin
            emit_load                = 1'b1;
            out_item_next            = '0;
            out_item_next.kind       = KIND_STATUS;
            out_item_next.gate       = gate_reg;
            out_item_next.retrigger  = any_reg;
            out_item_next.held_notes = HELD_W'(held_reg);
            out_item_next.last       = 1'b1;
        end

        if (emit_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STACK_DEPTH; k++)
            begin
                stack_reg[k] <= '0;
            end
            for (int j = 0; j < MAX_VOICES; j++)
            begin
                voice_reg[j] <= '0;
            end
            held_reg      <= '0;
            gate_reg      <= 1'b0;
            viu_reg       <= VIU_RESET;
            low_reg       <= LOW_RESET;
            span_reg      <= SPAN_RESET;
            idx_reg       <= '0;
            vidx_reg      <= '0;
            keep_reg      <= '0;
            found_reg     <= 1'b0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            stack_reg     <= stack_next;
            voice_reg     <= voice_next;
            held_reg      <= held_next;
            gate_reg      <= gate_next;
            viu_reg       <= viu_next;
            low_reg       <= low_next;
            span_reg      <= span_next;
            idx_reg       <= idx_next;
            vidx_reg      <= vidx_next;
            keep_reg      <= keep_next;
            found_reg     <= found_next;
            any_reg       <= any_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        pitch_reg     <= pitch_next;
        ok_reg        <= ok_next;
        found_idx_reg <= found_idx_next;
        out_item_reg  <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Checks
    `CHK_ALWAYS(a_held_range, held_reg <= CW'(STACK_DEPTH), "held count above stack depth")
    `CHK_SAME(a_emit_free, emit_load, out_free, "item written over a pending item")
    `CHK_NEXT(a_assign_gate, cmd.asg_step && asg_need, gate_reg && (held_reg != '0), "assign without gate")

endmodule

### hw/rtl/note_stack_voice_allocator_top.sv
// ---------------------------------------------------------------------------
// note_stack_voice_allocator_top
// Last-note priority voice allocator: a held-note stack feeds a window of
// voices; each event yields any releases and assignments, then one status item.
//
//   Channel  Signals                       Dir  Payload
//   in       in_valid / in_ready           in   nsva_in_t  (opcode, pitch)
//   out      out_valid / out_ready         out  nsva_out_t (kind .. last)
//   cfg      cfg_we, cfg_index, cfg_data   in   7-bit register write
//
// One item at a time. An event's length from accept to the next accept grows
// with the held notes before the event, the window after it and MAX_VOICES,
// set by the serial stack search, the window scans through the single stack
// read port and the voice-by-voice release pass; all-off, unused and rejected
// events go from decode straight to the status item. Each result waits for
// the output register to drain, so out_ready stalls stretch the event. Reset
// clears stack, voices and gate at once; there is no clearing pass.
// ---------------------------------------------------------------------------
module note_stack_voice_allocator_top
    import nsva_pkg::*;
#(
    parameter int MAX_VOICES  = MAX_VOICES_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  nsva_in_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output nsva_out_t             out_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    nsva_cmd_t  cmd;
    nsva_stat_t stat;

    // Sequencer
    nsva_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Stack, voices and output register
    nsva_dp #(
        .MAX_VOICES  (MAX_VOICES),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
